### design/pda_pkg.sv
// shared constants, state encoding and divider control types for the duty averager
package pda_pkg;

    localparam int WINDOW_DEF     = 10;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int CAPTURE_W      = 32;
    localparam int DAC_W          = 10;
    localparam int DUTY_W         = 7;
    localparam int PCT_FULL       = 100;
    localparam int DAC_FS_RESET   = 620;

    // quotient bits of the duty division: duty stays below 128
    localparam int DUTY_STEPS = DUTY_W;
    localparam int STEP_W     = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DUTY_GO,
        ST_DUTY_WAIT,
        ST_RING,
        ST_MEAN,
        ST_SCALE,
        ST_DAC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

endpackage

### design/pda_in_if.sv
// capture timestamp channel
interface pda_in_if;

    logic                           valid;
    logic                           ready;
    logic [pda_pkg::CAPTURE_W-1:0]  capture_time;

    modport source (output valid, output capture_time, input ready);
    modport sink   (input valid, input capture_time, output ready);

endinterface

### design/pda_out_if.sv
// duty result channel
interface pda_out_if;

    logic                        valid;
    logic                        ready;
    logic [pda_pkg::DAC_W-1:0]   dac_code;
    logic [pda_pkg::DUTY_W-1:0]  average_duty;
    logic [pda_pkg::DUTY_W-1:0]  latest_duty;
    logic                        zero_period;

    modport source (output valid, output dac_code, output average_duty,
                    output latest_duty, output zero_period, input ready);
    modport sink   (input valid, input dac_code, input average_duty,
                    input latest_duty, input zero_period, output ready);

endinterface

### design/pwm_duty_averager_unit.sv
// top level of the pwm duty averager: edge pairing, duty ring and output stage
// a falling edge beat is absorbed in idle and gives no result
// a rising edge beat runs fetch, the 7 step serial duty divide, ring update, mean, scaling and dac
// before the result loads; a zero period or a saturated high time skips the divide
// a new beat is taken once the result loads, a held result stalls
// reset clears pairing state, ring sum, ring index and the ring valid bits at once, no sweep
module pwm_duty_averager_unit #(
    parameter int WINDOW     = pda_pkg::WINDOW_DEF,
    parameter int TIME_WIDTH = pda_pkg::TIME_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    pda_in_if.sink                    capture,
    pda_out_if.source                 result,
    input  logic                      cfg_wr_en,
    input  logic [pda_pkg::DAC_W-1:0] cfg_wr_data
);

    localparam int TW     = TIME_WIDTH;
    localparam int DW     = pda_pkg::DUTY_W;
    localparam int QW     = pda_pkg::DAC_W;
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SUM_W  = $clog2(WINDOW * pda_pkg::PCT_FULL + 1);
    // holds high time times 100, and also mean times full scale
    localparam int NW     = (TW + DW > QW + DW) ? (TW + DW) : (QW + DW);

    // reciprocal constants: (x * rcp) >> sh equals x / divisor over the whole operand range
    localparam int     SC_W       = QW + DW;
    localparam int     MEAN_SH    = SUM_W + IDX_W;
    localparam longint MEAN_RCP   = ((longint'(1) << MEAN_SH) + WINDOW - 1) / WINDOW;
    localparam int     MEAN_RCP_W = $clog2(MEAN_RCP + 1);
    localparam int     MP_W       = SUM_W + MEAN_RCP_W;
    localparam int     DAC_SH     = SC_W + $clog2(pda_pkg::PCT_FULL);
    localparam longint DAC_RCP    =
        ((longint'(1) << DAC_SH) + pda_pkg::PCT_FULL - 1) / pda_pkg::PCT_FULL;
    localparam int     DAC_RCP_W  = $clog2(DAC_RCP + 1);
    localparam int     DP_W       = SC_W + DAC_RCP_W;

    // sequencer
    pda_pkg::state_t   state_reg;
    pda_pkg::state_t   state_next;

    // pairing state
    logic              expect_falling_reg;
    logic [TW-1:0]     last_rise_reg;
    logic [TW-1:0]     high_time_reg;

    // ring bookkeeping, entries live in the ram
    logic [IDX_W-1:0]  ring_idx_reg;
    logic [SUM_W-1:0]  ring_sum_reg;
    logic [WINDOW-1:0] ring_vld_reg;

    logic [QW-1:0]     full_scale_reg;

    // per rising edge working registers
    logic [TW-1:0]     period_reg;
    logic [NW-1:0]     num_reg;
    logic [DW-1:0]     old_duty_reg;
    logic [DW-1:0]     duty_reg;
    logic              zero_reg;
    logic [DW-1:0]     mean_reg;
    logic [QW-1:0]     dac_reg;

    // output stage
    logic              out_vld_reg;
    logic [QW-1:0]     out_dac_reg;
    logic [DW-1:0]     out_mean_reg;
    logic [DW-1:0]     out_duty_reg;
    logic              out_zero_reg;

    // combinational
    logic              cap_rdy;
    logic              cap_acc;
    logic [TW-1:0]     stamp;
    logic [TW-1:0]     stamp_diff;
    logic              sat_duty;
    logic              ram_we;
    logic [DW-1:0]     ram_rdata;
    logic              out_load;
    logic              out_free;
    logic [MP_W-1:0]   mean_prod;
    logic [DP_W-1:0]   dac_prod;

    pda_pkg::div_req_t div_req;
    logic [TW-1:0]     div_rem;
    logic [QW-1:0]     div_low;
    logic [TW-1:0]     div_dvs;
    logic              div_done;
    logic [QW-1:0]     div_quot;

    // only the low timer bits take part, differences wrap at the timer width
    assign stamp      = TW'(capture.capture_time);
    assign stamp_diff = stamp - last_rise_reg;
    assign cap_acc    = capture.valid && cap_rdy;
    assign sat_duty   = (high_time_reg >= period_reg);
    assign out_free   = !out_vld_reg || result.ready;

    // mean of the ring and dac scaling by reciprocal multiplication
    assign mean_prod  = MP_W'(ring_sum_reg) * MP_W'(MEAN_RCP);
    assign dac_prod   = DP_W'(num_reg[SC_W-1:0]) * DP_W'(DAC_RCP);

    // duty ring storage
    pda_ram #(
        .WIDTH (DW),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ring_idx_reg),
        .wdata (duty_reg),
        .raddr (ring_idx_reg),
        .rdata (ram_rdata)
    );

    // serial divider for the duty ratio
    pda_serial_div #(
        .DIV_W (TW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .rem_init (div_rem),
        .low_init (div_low),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pda_pkg::ST_IDLE:
            begin
                if (cap_acc && !expect_falling_reg)
                begin
                    state_next = pda_pkg::ST_FETCH;
                end
            end
            pda_pkg::ST_FETCH:
            begin
                // zero period and saturated duty skip the division
                if ((period_reg == '0) || sat_duty)
                begin
                    state_next = pda_pkg::ST_RING;
                end
                else
                begin
                    state_next = pda_pkg::ST_DUTY_GO;
                end
            end
            pda_pkg::ST_DUTY_GO:   state_next = pda_pkg::ST_DUTY_WAIT;
            pda_pkg::ST_DUTY_WAIT:
            begin
                if (div_done)
                begin
                    state_next = pda_pkg::ST_RING;
                end
            end
            pda_pkg::ST_RING:      state_next = pda_pkg::ST_MEAN;
            pda_pkg::ST_MEAN:      state_next = pda_pkg::ST_SCALE;
            pda_pkg::ST_SCALE:     state_next = pda_pkg::ST_DAC;
            pda_pkg::ST_DAC:       state_next = pda_pkg::ST_EMIT;
            pda_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = pda_pkg::ST_IDLE;
                end
            end
            default:               state_next = pda_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        cap_rdy       = 1'b0;
        ram_we        = 1'b0;
        out_load      = 1'b0;
        div_req.start = 1'b0;
        div_req.steps = pda_pkg::STEP_W'(pda_pkg::DUTY_STEPS);
        // duty: h*100/p with h below p, so the top bits already sit below the divisor
        div_rem       = TW'(num_reg >> pda_pkg::DUTY_STEPS);
        div_low       = QW'(num_reg[DW-1:0]) << (QW - DW);
        div_dvs       = period_reg;
        unique case (state_reg)
            pda_pkg::ST_IDLE:      cap_rdy = 1'b1;
            pda_pkg::ST_DUTY_GO:   div_req.start = 1'b1;
            pda_pkg::ST_RING:      ram_we = 1'b1;
            pda_pkg::ST_EMIT:      out_load = out_free;
            default:
            begin
                cap_rdy = 1'b0;
            end
        endcase
    end

    // control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= pda_pkg::ST_IDLE;
            expect_falling_reg <= 1'b0;
            last_rise_reg      <= '0;
            high_time_reg      <= '0;
            ring_idx_reg       <= '0;
            ring_sum_reg       <= '0;
            ring_vld_reg       <= '0;
            full_scale_reg     <= QW'(pda_pkg::DAC_FS_RESET);
            out_vld_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                full_scale_reg <= cfg_wr_data;
            end

            if (cap_acc)
            begin
                if (expect_falling_reg)
                begin
                    high_time_reg      <= stamp_diff;
                    expect_falling_reg <= 1'b0;
                end
                else
                begin
                    last_rise_reg      <= stamp;
                    expect_falling_reg <= 1'b1;
                end
            end

            if (ram_we)
            begin
                ring_sum_reg <= ring_sum_reg - SUM_W'(old_duty_reg) + SUM_W'(duty_reg);
                ring_vld_reg[ring_idx_reg] <= 1'b1;
                if (ring_idx_reg == IDX_W'(WINDOW - 1))
                begin
                    ring_idx_reg <= '0;
                end
                else
                begin
                    ring_idx_reg <= ring_idx_reg + 1'b1;
                end
            end

            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // working data path
    always_ff @(posedge clk)
    begin
        if (cap_acc && !expect_falling_reg)
        begin
            period_reg <= stamp_diff;
        end

        unique case (state_reg)
            pda_pkg::ST_FETCH:
            begin
                num_reg      <= NW'(high_time_reg) * NW'(pda_pkg::PCT_FULL);
                // entries never written read as zero
                old_duty_reg <= ring_vld_reg[ring_idx_reg] ? ram_rdata : '0;
                zero_reg     <= (period_reg == '0);
                if (period_reg == '0)
                begin
                    duty_reg <= '0;
                end
                else if (sat_duty)
                begin
                    duty_reg <= DW'(pda_pkg::PCT_FULL);
                end
            end
            pda_pkg::ST_DUTY_WAIT:
            begin
                if (div_done)
                begin
                    duty_reg <= div_quot[DW-1:0];
                end
            end
            pda_pkg::ST_MEAN:
            begin
                mean_reg <= DW'(mean_prod >> MEAN_SH);
            end
            pda_pkg::ST_SCALE:
            begin
                num_reg <= NW'(mean_reg) * NW'(full_scale_reg);
            end
            pda_pkg::ST_DAC:
            begin
                dac_reg <= QW'(dac_prod >> DAC_SH);
            end
            default:
            begin
                num_reg <= num_reg;
            end
        endcase

        if (out_load)
        begin
            out_dac_reg  <= dac_reg;
            out_mean_reg <= mean_reg;
            out_duty_reg <= duty_reg;
            out_zero_reg <= zero_reg;
        end
    end

    assign capture.ready       = cap_rdy;
    assign result.valid        = out_vld_reg;
    assign result.dac_code     = out_dac_reg;
    assign result.average_duty = out_mean_reg;
    assign result.latest_duty  = out_duty_reg;
    assign result.zero_period  = out_zero_reg;

    // divider only finishes while the sequencer waits on it
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == pda_pkg::ST_DUTY_WAIT))
        else $error("divider finished outside a wait state");

    // running sum never exceeds a full window at 100 percent
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_sum_reg <= SUM_W'(WINDOW * pda_pkg::PCT_FULL))
        else $error("ring sum out of range");

    // a falling edge beat leaves the sequencer idle
    a_fall_absorbed: assert property (@(posedge clk) disable iff (!rst_n)
        (cap_acc && expect_falling_reg) |=> (state_reg == pda_pkg::ST_IDLE))
        else $error("falling edge started a computation");

    // zero period always carries a zero duty
    a_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_zero_reg) |-> (out_duty_reg == '0))
        else $error("zero period with nonzero duty");

    // averages stay within percent range
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_mean_reg <= DW'(pda_pkg::PCT_FULL) &&
                         out_duty_reg <= DW'(pda_pkg::PCT_FULL)))
        else $error("percent value above full scale");

endmodule

### design/pda_ram.sv
// generic single write port ram with registered read
module pda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/pda_serial_div.sv
// restoring divider, one quotient bit per cycle, preloaded partial remainder
module pda_serial_div #(
    parameter int DIV_W = pda_pkg::TIME_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pda_pkg::div_req_t         req,
    input  logic [DIV_W-1:0]          rem_init,
    input  logic [pda_pkg::DAC_W-1:0] low_init,
    input  logic [DIV_W-1:0]          divisor,
    output logic                      done,
    output logic [pda_pkg::DAC_W-1:0] quotient
);

    localparam int QW = pda_pkg::DAC_W;

    logic                       busy_reg;
    logic                       done_reg;
    logic [pda_pkg::STEP_W-1:0] cnt_reg;
    logic [DIV_W-1:0]           rem_reg;
    logic [DIV_W-1:0]           dvs_reg;
    logic [QW-1:0]              low_reg;
    logic [QW-1:0]              q_reg;

    logic [DIV_W:0]             trial;
    logic                       fits;

    // bring down the next dividend bit and try the subtraction
    assign trial = {rem_reg, low_reg[QW-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == pda_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= rem_init;
            low_reg <= low_init;
            dvs_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
            low_reg <= {low_reg[QW-2:0], 1'b0};
            q_reg   <= {q_reg[QW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### test/tb_pwm_duty_averager_unit.sv
// self-checking testbench for the pwm duty averager: edge timestamps in, duty and dac results out
module tb_pwm_duty_averager_unit;

    timeunit 1ns;
    timeprecision 1ps;

    // ring depth as built into the unit under test
    localparam int WINDOW       = pda_pkg::WINDOW_DEF;
    localparam int SETTLE_CYCLES = 10;     // a falling edge beat is absorbed without leaving idle
    localparam int TAIL_CYCLES   = 40;     // longer than one full rising edge computation
    localparam int CYCLE_LIMIT   = 400000; // several times the slowest legal run

    typedef struct packed {
        logic [pda_pkg::DAC_W-1:0]  dac_code;
        logic [pda_pkg::DUTY_W-1:0] average_duty;
        logic [pda_pkg::DUTY_W-1:0] latest_duty;
        logic                       zero_period;
    } duty_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                      cfg_wr_en;
    logic [pda_pkg::DAC_W-1:0] cfg_wr_data;

    pda_in_if  capture_bus ();
    pda_out_if result_bus ();

    pwm_duty_averager_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .capture     (capture_bus),
        .result      (result_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the meter state, starting from its reset values
    logic                       pwm_want_fall = 1'b0;
    logic [31:0]                pwm_last_rise = '0;
    logic [31:0]                pwm_high_time = '0;
    logic [pda_pkg::DUTY_W-1:0] duty_hist [WINDOW];
    int                         hist_slot = 0;
    int unsigned                hist_sum = 0;
    logic [pda_pkg::DAC_W-1:0]  model_full_scale = pda_pkg::DAC_W'(pda_pkg::DAC_FS_RESET);

    duty_result_t pending_duty_results [$];

    int    mismatch_count = 0;
    int    cycle_count = 0;
    bit    steady_mode = 1'b0;

    // cursors for well-formed pwm trains in the random traffic
    logic [31:0] rise_cursor;
    logic [31:0] fall_cursor;

    initial
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            duty_hist[i] = '0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // advance the shadow state by one accepted edge beat; a rising edge queues one result
    function automatic void predict_duty_edge(input logic [31:0] stamp);
        logic [31:0]                span;
        logic [63:0]                scaled;
        logic [pda_pkg::DUTY_W-1:0] duty;
        int unsigned                mean;
        duty_result_t               res;
        if (pwm_want_fall)
        begin
            // falling edge only records how long the line was high
            pwm_high_time = stamp - pwm_last_rise;
            pwm_want_fall = 1'b0;
            return;
        end
        span = stamp - pwm_last_rise;
        pwm_last_rise = stamp;
        pwm_want_fall = 1'b1;
        res.zero_period = (span == 0);
        if (span == 0)
        begin
            duty = '0;
        end
        else if (pwm_high_time >= span)
        begin
            duty = pda_pkg::DUTY_W'(pda_pkg::PCT_FULL);
        end
        else
        begin
            // high time below period, so the quotient stays under 100
            scaled = (64'(pwm_high_time) * 64'(pda_pkg::PCT_FULL)) / 64'(span);
            duty = scaled[pda_pkg::DUTY_W-1:0];
        end
        hist_sum = hist_sum - 32'(duty_hist[hist_slot]) + 32'(duty);
        duty_hist[hist_slot] = duty;
        hist_slot = (hist_slot == WINDOW - 1) ? 0 : hist_slot + 1;
        mean = hist_sum / WINDOW;
        res.latest_duty = duty;
        res.average_duty = pda_pkg::DUTY_W'(mean);
        res.dac_code = pda_pkg::DAC_W'((mean * model_full_scale) / pda_pkg::PCT_FULL);
        pending_duty_results.push_back(res);
    endfunction

    // result sink: random back-pressure, none while in steady mode
    always @(posedge clk)
    begin
        result_bus.ready <= steady_mode || ($urandom_range(0, 99) >= 25);
    end

    // compare every accepted result beat with the oldest prediction
    always @(posedge clk)
    begin
        duty_result_t got;
        duty_result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = '{result_bus.dac_code, result_bus.average_duty,
                    result_bus.latest_duty, result_bus.zero_period};
            if (pending_duty_results.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing pending: dac %0d avg %0d",
                                          got.dac_code, got.average_duty));
            end
            else
            begin
                want = pending_duty_results.pop_front();
                if (got !== want)
                begin
                    report_mismatch($sformatf(
                        "dac %0d/%0d avg %0d/%0d latest %0d/%0d zero %0b/%0b (got/want)",
                        got.dac_code, want.dac_code, got.average_duty, want.average_duty,
                        got.latest_duty, want.latest_duty, got.zero_period,
                        want.zero_period));
                end
            end
        end
    end

    // watchdog, in case the unit hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL pwm_duty_averager_unit");
            $finish;
        end
    end

    // one capture beat; valid is left high on return so back-to-back beats need no dip
    task automatic send_capture(input logic [31:0] stamp);
        if (!steady_mode && $urandom_range(0, 99) < 25)
        begin
            capture_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        capture_bus.valid <= 1'b1;
        capture_bus.capture_time <= stamp;
        @(posedge clk);
        while (!capture_bus.ready)
        begin
            @(posedge clk);
        end
        predict_duty_edge(stamp);
    endtask

    // falling then rising edge, both relative to the last rise
    task automatic send_pair(input logic [31:0] high, input logic [31:0] span);
        logic [31:0] base;
        base = pwm_last_rise;
        send_capture(base + high);
        send_capture(base + span);
    endtask

    // drop valid, let every pending result out, then allow for a falling edge still in hand
    task automatic await_quiet();
        capture_bus.valid <= 1'b0;
        while (pending_duty_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only ever called with the unit idle
    task automatic write_full_scale(input logic [pda_pkg::DAC_W-1:0] code);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= code;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_full_scale = code;
    endtask

    // period mix: short most often, some mid-range, a few near the full timer range, rarely zero
    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2, 3, 4: return $urandom_range(1, 200);
            5, 6, 7: return $urandom_range(1, 65535);
            8:       return $urandom;
            default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [31:0] pick_high(input logic [31:0] span);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return span;
            2:       return span + $urandom_range(1, 50);
            default: return (span == 0) ? '0 : ($urandom % span);
        endcase
    endfunction

    // next beat of a pwm train; noisy beats jump to a random timestamp
    task automatic send_shaped_edge(input bit saturate, input bit noisy);
        logic [31:0] stamp;
        logic [31:0] span;
        logic [31:0] high;
        if (!pwm_want_fall)
        begin
            stamp = noisy ? $urandom : rise_cursor;
            if (saturate)
            begin
                span = $urandom_range(1, 100000);
                high = span + $urandom_range(0, 50);
            end
            else
            begin
                span = pick_period();
                high = pick_high(span);
            end
            fall_cursor = stamp + high;
            rise_cursor = stamp + span;
        end
        else
        begin
            stamp = noisy ? $urandom : fall_cursor;
        end
        send_capture(stamp);
    endtask

    task automatic run_random_phase(input logic [pda_pkg::DAC_W-1:0] full_scale,
                                    input int beats, input int sat_cycles, input bit steady);
        await_quiet();
        write_full_scale(full_scale);
        steady_mode = steady;
        rise_cursor = $urandom;
        fall_cursor = pwm_last_rise + $urandom_range(0, 1000);
        // saturated lead-in fills the ring with full duty so the average reaches 100
        for (int i = 0; i < 2 * sat_cycles; i++)
        begin
            send_shaped_edge(1'b1, 1'b0);
        end
        for (int i = 0; i < beats; i++)
        begin
            send_shaped_edge(1'b0, $urandom_range(0, 99) < 12);
        end
        steady_mode = 1'b0;
    endtask

    // first rising edge measures its period from time zero, then a plain quarter duty
    task automatic test_first_rise_from_zero();
        send_capture(32'd100);
        send_pair(32'd25, 32'd100);
    endtask

    // rising edge at the same stamp as the last one: zero period, 0 still enters the ring
    task automatic test_zero_period();
        send_pair(32'd40, 32'd0);
    endtask

    // high time above and equal to the period saturates at 100
    task automatic test_saturation();
        send_pair(32'd500, 32'd200);
        send_pair(32'd300, 32'd300);
    endtask

    // timer extremes and differences that wrap through zero
    task automatic test_wrap_and_extremes();
        send_pair(32'd0, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_capture(32'h0000_0000);
        send_capture(32'hFFFF_FFFF);
        send_capture(32'h0000_0010);
        send_capture(32'h0000_0400);
    endtask

    // full scale at both ends of its range
    task automatic test_full_scale_extremes();
        await_quiet();
        write_full_scale(10'h3FF);
        send_pair(32'd7, 32'd9);
        await_quiet();
        write_full_scale(10'h000);
        send_pair(32'd9, 32'd9);
    endtask

    // sender holds off until every result is out, then carries on mid-train
    task automatic test_pause_until_drained();
        send_pair(32'd33, 32'd77);
        await_quiet();
        send_pair(32'd1, 32'd3);
        send_pair(32'd1000, 32'd4000);
    endtask

    // random traffic over several full scale settings, one phase with no idling at all
    task automatic test_random_traffic();
        run_random_phase(pda_pkg::DAC_W'(pda_pkg::DAC_FS_RESET), 220, 0, 1'b0);
        run_random_phase(10'h3FF, 150, 12, 1'b1);
        run_random_phase(10'h000, 100, 0, 1'b0);
        run_random_phase(pda_pkg::DAC_W'($urandom_range(1, 1022)), 180, 0, 1'b0);
        run_random_phase(pda_pkg::DAC_W'($urandom_range(1, 1022)), 150, 0, 1'b0);
    endtask

    initial
    begin
        // every input known from time zero
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        capture_bus.valid = 1'b0;
        capture_bus.capture_time = '0;
        result_bus.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_rise_from_zero();
        test_zero_period();
        test_saturation();
        test_wrap_and_extremes();
        test_full_scale_extremes();
        test_pause_until_drained();
        test_random_traffic();

        // drain, then watch a while longer for stray result beats
        await_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS pwm_duty_averager_unit");
        end
        else
        begin
            $display("FAIL pwm_duty_averager_unit");
        end
        $finish;
    end

endmodule
